>>> hw/rtl/isl_pkg.sv
// Shared types and constants for the indexed shift list.
`timescale 1ns / 1ps

package isl_pkg;

    // Width of the slot number that every cell compares against.
    localparam int SLOT_W = 8;

    // Operation codes carried in the request.
    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5,
        OP_WRITE  = 3'd6
    } isl_op_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } isl_status_t;

    // What the row of cells does on the next edge.
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_LOAD = 2'd1,
        SH_UP   = 2'd2,
        SH_DOWN = 2'd3
    } isl_shift_t;

    // Command broadcast to every cell.
    typedef struct packed {
        isl_shift_t          kind;
        logic [SLOT_W-1:0]   slot;
    } isl_cmd_t;

endpackage

>>> hw/rtl/isl_cell.sv
// One storage cell of the list row, taking from its neighbors on shifts.
`timescale 1ns / 1ps

module isl_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  isl_pkg::isl_cmd_t      cmd,
    input  logic [DATA_WIDTH-1:0]  word,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    output logic [DATA_WIDTH-1:0]  entry
);
    import isl_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.kind)
            SH_LOAD:
            begin
                if (cmd.slot == MY_SLOT)
                    entry_next = word;
            end
            SH_UP:
            begin
                // The addressed cell takes the new word, cells above it take the one below.
                if (cmd.slot == MY_SLOT)
                    entry_next = word;
                else if (MY_SLOT > cmd.slot)
                    entry_next = left_data;
            end
            SH_DOWN:
            begin
                if (MY_SLOT >= cmd.slot)
                    entry_next = right_data;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hw/rtl/isl_ctrl.sv
// Request decoder: bounds checks, status, next count and the cell command.
`timescale 1ns / 1ps

module isl_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic [2:0]                     func,
    input  logic [3:0]                     index,
    input  logic [$clog2(DEPTH+1)-1:0]     held,
    output isl_pkg::isl_cmd_t              cmd,
    output logic [$clog2(DEPTH+1)-1:0]     held_next,
    output isl_pkg::isl_status_t           status,
    output logic                           read_en
);
    import isl_pkg::*;

    localparam int HW = $clog2(DEPTH + 1);
    localparam int PW = (HW > 4) ? HW : 4;
    localparam logic [HW-1:0] DEPTH_H = HW'(DEPTH);

    logic [PW-1:0]  pos_ext;
    logic [PW-1:0]  held_ext;
    logic           is_empty;
    logic           is_full;
    logic           in_range;
    isl_status_t    slot_status;
    isl_op_t        op;

    assign pos_ext  = PW'(index);
    assign held_ext = PW'(held);
    assign is_empty = (held == '0);
    assign is_full  = (held >= DEPTH_H);
    assign in_range = (pos_ext < held_ext);
    assign op       = isl_op_t'(func);

    // Shared check for erase, read and write.
    always_comb
    begin
        if (is_empty)
            slot_status = ST_EMPTY;
        else if (!in_range)
            slot_status = ST_RANGE;
        else
            slot_status = ST_OK;
    end

    always_comb
    begin
        cmd.kind  = SH_HOLD;
        cmd.slot  = SLOT_W'(index);
        held_next = held;
        status    = ST_OK;
        read_en   = 1'b0;
        unique case (op)
            OP_APPEND:
            begin
                if (is_full)
                    status = ST_FULL;
                else
                begin
                    cmd.kind  = SH_LOAD;
                    cmd.slot  = SLOT_W'(held);
                    held_next = held + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (is_empty)
                    status = ST_EMPTY;
                else
                    held_next = held - 1'b1;
            end
            OP_INSERT:
            begin
                // Insert may only place a word before an existing entry.
                if (!in_range)
                    status = ST_RANGE;
                else if (is_full)
                    status = ST_FULL;
                else
                begin
                    cmd.kind  = SH_UP;
                    held_next = held + 1'b1;
                end
            end
            OP_ERASE:
            begin
                status = slot_status;
                if (slot_status == ST_OK)
                begin
                    cmd.kind  = SH_DOWN;
                    held_next = held - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                held_next = '0;
            end
            OP_READ:
            begin
                status  = slot_status;
                read_en = (slot_status == ST_OK);
            end
            OP_WRITE:
            begin
                status = slot_status;
                if (slot_status == ST_OK)
                    cmd.kind = SH_LOAD;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

endmodule

>>> hw/rtl/indexed_shift_list_unit.sv
// Top level of the indexed shift list: cell row, decoder and result register.
`timescale 1ns / 1ps

// The indexed shift list holds up to DEPTH words in order and serves one
// request per clock cycle: append, remove last, insert at an index, erase at
// an index, clear, read at an index, or write at an index. The words live in
// a row of cells; on an insert every cell above the index takes the word of
// its lower neighbor and on an erase every cell from the index up takes the
// word of its upper neighbor, all on the same edge, so every request is done by
// a single update of the cell row together with the entry count register. Each
// request returns one result in the cycle after it is taken, from an output
// register: the read data (zero unless
// a read succeeded), the count after the request, and a status of ok, empty,
// index out of range or full. A new request is taken whenever the output
// register is empty or its result is being taken in the same cycle. Erase,
// read and write are checked against the current count; insert requires an
// index below the count, so it cannot be used on an empty list. Only the
// first sixteen positions can be addressed by index. Stored words are kept
// to DATA_WIDTH bits; read data is returned in 32 bits.
module indexed_shift_list_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // index[3:0], value[35:4], zero[39:36]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[31:0], count[36:32], zero[39:37]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import isl_pkg::*;

    localparam int HW = $clog2(DEPTH + 1);
    // Positions reachable through the four-bit index.
    localparam int NR = (DEPTH < 16) ? DEPTH : 16;

    logic [3:0]            index;
    logic [31:0]           value;
    logic [2:0]            func;
    logic [63:0]           value_wide;
    logic [DATA_WIDTH-1:0] word;

    logic [HW-1:0]         held_reg;
    logic [HW-1:0]         held_next;
    isl_cmd_t              cmd;
    isl_cmd_t              cmd_gated;
    isl_status_t           status;
    logic                  read_en;
    logic                  accept;

    logic [DATA_WIDTH-1:0] entry [DEPTH];
    logic [DATA_WIDTH-1:0] rd_sel;
    logic [63:0]           rd_wide;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [31:0]           rdata_reg;
    logic [4:0]            count_reg;
    isl_status_t           status_reg;

    assign index      = s_tdata[3:0];
    assign value      = s_tdata[35:4];
    assign func       = s_tuser;
    assign value_wide = {32'd0, value};
    assign word       = value_wide[DATA_WIDTH-1:0];

    // A request enters when the result register is free or draining.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    isl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .func      (func),
        .index     (index),
        .held      (held_reg),
        .cmd       (cmd),
        .held_next (held_next),
        .status    (status),
        .read_en   (read_en)
    );

    // The cells only move on an accepted request.
    always_comb
    begin
        cmd_gated = cmd;
        if (!accept)
            cmd_gated.kind = SH_HOLD;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_inner_l
            assign left_data = entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = entry[i];
        end
        else
        begin : g_inner_r
            assign right_data = entry[i+1];
        end

        isl_cell #(
            .IDX        (i),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd_gated),
            .word       (word),
            .left_data  (left_data),
            .right_data (right_data),
            .entry      (entry[i])
        );
    end

    // Read port: pick the addressed cell among the ones the index can reach.
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < NR; i++)
        begin
            if (index == 4'(i))
                rd_sel = rd_sel | entry[i];
        end
    end

    assign rd_wide = 64'(rd_sel);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (accept)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (accept)
                held_reg <= held_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg  <= read_en ? rd_wide[31:0] : 32'd0;
            count_reg  <= 5'(held_next);
            status_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, count_reg, rdata_reg};
    assign m_tuser  = status_reg;

endmodule
